### rtl/dmdl_pkg.sv
// Shared widths, codes, reset values and types of the door motor duty limiter.
package dmdl_pkg;

  localparam int unsigned SecW     = 16;
  localparam int unsigned FactorW  = 8;
  localparam int unsigned TpsW     = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned OpW      = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned NeedW    = SecW + FactorW;

  localparam logic [OpW-1:0] OP_TICK    = 2'd0;
  localparam logic [OpW-1:0] OP_SET_POS = 2'd1;
  localparam logic [OpW-1:0] OP_WRITE   = 2'd2;
  localparam logic [OpW-1:0] OP_READ    = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_MAX_RUN = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FACTOR  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_TPS     = 2'd2;

  localparam logic [ByteW-1:0] POS_COUNT   = 8'd0;
  localparam logic [ByteW-1:0] POS_COMMAND = 8'd1;

  localparam logic [ByteW-1:0] CMD_RAISE       = 8'd10;
  localparam logic [ByteW-1:0] CMD_LOWER       = 8'd20;
  localparam logic [ByteW-1:0] CMD_VALVE_FWD   = 8'd40;
  localparam logic [ByteW-1:0] CMD_VALVE_REV   = 8'd50;
  localparam logic [ByteW-1:0] CMD_VALVE_OFF   = 8'd60;
  localparam logic [ByteW-1:0] CMD_STOP_MOTORS = 8'd70;

  localparam logic [SecW-1:0]    MAX_RUN_RESET = 16'd60;
  localparam logic [FactorW-1:0] FACTOR_RESET  = 8'(1080 / 120);
  localparam logic [TpsW-1:0]    TPS_RESET     = 16'd200;

  typedef struct packed {
    logic running;
    logic cooling;
  } duty_flags_t;

  typedef struct packed {
    logic [SecW-1:0] run;
    logic [SecW-1:0] idle;
  } duty_timers_t;

endpackage

### rtl/dmdl_in_if.sv
// Input channel: one bus access or tick word per handshake.
interface dmdl_in_if;
  logic                        valid;
  logic                        ready;
  logic [dmdl_pkg::OpW-1:0]    operation;
  logic [dmdl_pkg::ByteW-1:0]  data;

  modport source (output valid, operation, data, input ready);
  modport sink (input valid, operation, data, output ready);
endinterface

### rtl/dmdl_out_if.sv
// Output channel: read byte, drive lines and timer flags per handshake.
interface dmdl_out_if;
  logic                       valid;
  logic                       ready;
  logic [dmdl_pkg::ByteW-1:0] read_data;
  logic                       motor1_forward;
  logic                       motor1_reverse;
  logic                       motor2_forward;
  logic                       motor2_reverse;
  logic                       valve_forward;
  logic                       valve_reverse;
  logic                       raise_running;
  logic                       raise_cooling;
  logic                       lower_running;
  logic                       lower_cooling;

  modport source (output valid, read_data, motor1_forward, motor1_reverse, motor2_forward,
                  motor2_reverse, valve_forward, valve_reverse, raise_running,
                  raise_cooling, lower_running, lower_cooling, input ready);
  modport sink (input valid, read_data, motor1_forward, motor1_reverse, motor2_forward,
                motor2_reverse, valve_forward, valve_reverse, raise_running,
                raise_cooling, lower_running, lower_cooling, output ready);
endinterface

### rtl/dmdl_duty.sv
// Run and cooldown evaluation of one direction, including the same-step restart.
module dmdl_duty (
  input  dmdl_pkg::duty_timers_t         timers,
  input  logic [dmdl_pkg::SecW-1:0]      max_run,
  input  logic [dmdl_pkg::FactorW-1:0]   factor,
  output dmdl_pkg::duty_timers_t         timers_next,
  output dmdl_pkg::duty_flags_t          flags_next,
  output logic                           drive
);

  logic [dmdl_pkg::NeedW-1:0] need;
  logic                       over;
  logic                       rested;

  assign need   = dmdl_pkg::NeedW'(factor) * dmdl_pkg::NeedW'(timers.run);
  assign over   = timers.run > max_run;
  assign rested = dmdl_pkg::NeedW'(timers.idle) >= need;

  // A finished cooldown clears the run timer, and a run timer of zero never
  // exceeds the limit, so the restart always lands in the running case.
  always_comb begin
    if (!over) begin
      timers_next = '{run: timers.run, idle: '0};
      flags_next  = '{running: 1'b1, cooling: 1'b0};
      drive       = 1'b1;
    end else if (rested) begin
      timers_next = '{run: '0, idle: '0};
      flags_next  = '{running: 1'b1, cooling: 1'b0};
      drive       = 1'b1;
    end else begin
      timers_next = timers;
      flags_next  = '{running: 1'b0, cooling: 1'b1};
      drive       = 1'b0;
    end
  end

endmodule

### rtl/door_motor_duty_limiter.sv
// Door motor duty limiter top level: bus slave, command decode and duty-limited motor drive.
// Each input word is registered, then applied to the bus registers, the
// prescaler and the second counters, and the stored command is evaluated to give one
// result word. An input word is accepted every cycle while the result register is free
// or being taken, so the block sustains one word per clock; the registered word moves to
// the result register when that is free. Configuration writes take effect at once.
module door_motor_duty_limiter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [dmdl_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dmdl_pkg::CfgDataW-1:0]  cfg_data,
  dmdl_in_if.sink                        in_ch,
  dmdl_out_if.source                     out_ch
);

  logic [dmdl_pkg::SecW-1:0]    max_run;
  logic [dmdl_pkg::FactorW-1:0] factor;
  logic [dmdl_pkg::TpsW-1:0]    tps;

  logic                         s1_valid;
  logic [dmdl_pkg::OpW-1:0]     s1_op;
  logic [dmdl_pkg::ByteW-1:0]   s1_data;

  logic [dmdl_pkg::TpsW-1:0]    prescaler;
  logic [dmdl_pkg::ByteW-1:0]   position;
  logic [dmdl_pkg::ByteW-1:0]   count;
  logic [dmdl_pkg::ByteW-1:0]   command;
  dmdl_pkg::duty_flags_t        raise_flags;
  dmdl_pkg::duty_flags_t        lower_flags;
  dmdl_pkg::duty_timers_t       raise_timers;
  dmdl_pkg::duty_timers_t       lower_timers;
  logic                         motor_fwd;
  logic                         motor_rev;
  logic                         valve_fwd;
  logic                         valve_rev;

  logic [dmdl_pkg::TpsW-1:0]    prescaler_next;
  logic [dmdl_pkg::ByteW-1:0]   position_next;
  logic [dmdl_pkg::ByteW-1:0]   count_next;
  logic [dmdl_pkg::ByteW-1:0]   command_next;
  dmdl_pkg::duty_flags_t        raise_flags_next;
  dmdl_pkg::duty_flags_t        lower_flags_next;
  dmdl_pkg::duty_timers_t       raise_timers_next;
  dmdl_pkg::duty_timers_t       lower_timers_next;
  logic                         motor_fwd_next;
  logic                         motor_rev_next;
  logic                         valve_fwd_next;
  logic                         valve_rev_next;
  logic [dmdl_pkg::ByteW-1:0]   rd;

  logic [dmdl_pkg::TpsW-1:0]    prescaler_inc;
  logic                         sec_tick;
  dmdl_pkg::duty_timers_t       raise_ticked;
  dmdl_pkg::duty_timers_t       lower_ticked;
  dmdl_pkg::duty_timers_t       raise_eval_timers;
  dmdl_pkg::duty_timers_t       lower_eval_timers;
  dmdl_pkg::duty_flags_t        raise_eval_flags;
  dmdl_pkg::duty_flags_t        lower_eval_flags;
  logic                         raise_drive;
  logic                         lower_drive;

  logic                         out_valid;
  logic                         out_free;
  logic                         advance;

  function automatic logic [dmdl_pkg::SecW-1:0] sat_inc(input logic [dmdl_pkg::SecW-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  assign out_free    = !out_valid || out_ch.ready;
  assign advance     = s1_valid && out_free;
  assign in_ch.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_run <= dmdl_pkg::MAX_RUN_RESET;
      factor  <= dmdl_pkg::FACTOR_RESET;
      tps     <= dmdl_pkg::TPS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dmdl_pkg::REG_MAX_RUN: max_run <= cfg_data[dmdl_pkg::SecW-1:0];
        dmdl_pkg::REG_FACTOR:  factor  <= cfg_data[dmdl_pkg::FactorW-1:0];
        dmdl_pkg::REG_TPS:     tps     <= cfg_data[dmdl_pkg::TpsW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op   <= in_ch.operation;
      s1_data <= in_ch.data;
    end
  end

  // Bus access and tick, applied before the command is evaluated.
  always_comb begin
    prescaler_inc = sat_inc(prescaler);
    sec_tick      = (s1_op == dmdl_pkg::OP_TICK) && (prescaler_inc >= tps);
    prescaler_next = prescaler;
    position_next  = position;
    count_next     = count;
    command_next   = command;
    rd             = '0;
    case (s1_op)
      dmdl_pkg::OP_TICK: begin
        prescaler_next = sec_tick ? '0 : prescaler_inc;
      end
      dmdl_pkg::OP_SET_POS: begin
        position_next = s1_data;
      end
      dmdl_pkg::OP_WRITE: begin
        if (position == dmdl_pkg::POS_COUNT) begin
          count_next = s1_data;
        end else if (position == dmdl_pkg::POS_COMMAND) begin
          command_next = s1_data;
        end
      end
      dmdl_pkg::OP_READ: begin
        if (position == dmdl_pkg::POS_COUNT) begin
          rd = count;
        end else if (position == dmdl_pkg::POS_COMMAND) begin
          rd = command;
        end
      end
      default: ;
    endcase
    raise_ticked.run  = (sec_tick && raise_flags.running) ? sat_inc(raise_timers.run)
                                                          : raise_timers.run;
    raise_ticked.idle = (sec_tick && raise_flags.cooling) ? sat_inc(raise_timers.idle)
                                                          : raise_timers.idle;
    lower_ticked.run  = (sec_tick && lower_flags.running) ? sat_inc(lower_timers.run)
                                                          : lower_timers.run;
    lower_ticked.idle = (sec_tick && lower_flags.cooling) ? sat_inc(lower_timers.idle)
                                                          : lower_timers.idle;
  end

  dmdl_duty u_raise (
    .timers      (raise_ticked),
    .max_run     (max_run),
    .factor      (factor),
    .timers_next (raise_eval_timers),
    .flags_next  (raise_eval_flags),
    .drive       (raise_drive)
  );

  dmdl_duty u_lower (
    .timers      (lower_ticked),
    .max_run     (max_run),
    .factor      (factor),
    .timers_next (lower_eval_timers),
    .flags_next  (lower_eval_flags),
    .drive       (lower_drive)
  );

  always_comb begin
    raise_timers_next = raise_ticked;
    lower_timers_next = lower_ticked;
    raise_flags_next  = raise_flags;
    lower_flags_next  = lower_flags;
    motor_fwd_next    = motor_fwd;
    motor_rev_next    = motor_rev;
    valve_fwd_next    = valve_fwd;
    valve_rev_next    = valve_rev;
    case (command_next)
      dmdl_pkg::CMD_RAISE: begin
        raise_timers_next = raise_eval_timers;
        raise_flags_next  = raise_eval_flags;
        motor_fwd_next    = raise_drive;
        motor_rev_next    = 1'b0;
      end
      dmdl_pkg::CMD_LOWER: begin
        lower_timers_next = lower_eval_timers;
        lower_flags_next  = lower_eval_flags;
        motor_fwd_next    = 1'b0;
        motor_rev_next    = lower_drive;
      end
      dmdl_pkg::CMD_VALVE_FWD: begin
        valve_fwd_next = 1'b1;
        valve_rev_next = 1'b0;
      end
      dmdl_pkg::CMD_VALVE_REV: begin
        valve_fwd_next = 1'b0;
        valve_rev_next = 1'b1;
      end
      dmdl_pkg::CMD_VALVE_OFF: begin
        valve_fwd_next = 1'b0;
        valve_rev_next = 1'b0;
      end
      dmdl_pkg::CMD_STOP_MOTORS: begin
        raise_timers_next = '0;
        lower_timers_next = '0;
        raise_flags_next  = '0;
        lower_flags_next  = '0;
        motor_fwd_next    = 1'b0;
        motor_rev_next    = 1'b0;
      end
      default: begin
        raise_timers_next = '0;
        lower_timers_next = '0;
        raise_flags_next  = '0;
        lower_flags_next  = '0;
        motor_fwd_next    = 1'b0;
        motor_rev_next    = 1'b0;
        valve_fwd_next    = 1'b0;
        valve_rev_next    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescaler    <= '0;
      position     <= '0;
      count        <= '0;
      command      <= '0;
      raise_flags  <= '0;
      lower_flags  <= '0;
      raise_timers <= '0;
      lower_timers <= '0;
      motor_fwd    <= 1'b0;
      motor_rev    <= 1'b0;
      valve_fwd    <= 1'b0;
      valve_rev    <= 1'b0;
    end else if (advance) begin
      prescaler    <= prescaler_next;
      position     <= position_next;
      count        <= count_next;
      command      <= command_next;
      raise_flags  <= raise_flags_next;
      lower_flags  <= lower_flags_next;
      raise_timers <= raise_timers_next;
      lower_timers <= lower_timers_next;
      motor_fwd    <= motor_fwd_next;
      motor_rev    <= motor_rev_next;
      valve_fwd    <= valve_fwd_next;
      valve_rev    <= valve_rev_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.read_data      <= rd;
      out_ch.motor1_forward <= motor_fwd_next;
      out_ch.motor1_reverse <= motor_rev_next;
      out_ch.motor2_forward <= motor_fwd_next;
      out_ch.motor2_reverse <= motor_rev_next;
      out_ch.valve_forward  <= valve_fwd_next;
      out_ch.valve_reverse  <= valve_rev_next;
      out_ch.raise_running  <= raise_flags_next.running;
      out_ch.raise_cooling  <= raise_flags_next.cooling;
      out_ch.lower_running  <= lower_flags_next.running;
      out_ch.lower_cooling  <= lower_flags_next.cooling;
    end
  end

  assign out_ch.valid = out_valid;

`ifndef NO_ASSERTIONS
  a_raise_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(raise_flags.running && raise_flags.cooling))
    else $error("Raise run and cooldown flags are both set.");

  a_motor_direction: assert property (@(posedge clk) disable iff (rst)
    !(motor_fwd && motor_rev))
    else $error("Motors are driven forward and reverse at once.");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("A processed word did not reach the result register.");

  a_stalled_word_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> s1_valid)
    else $error("A registered input word was dropped while the output stalled.");

  a_reset_clears_output: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("Result valid after reset.");
`endif

endmodule

### test/tb_top.sv
// Testbench of the door motor duty limiter: directed table and random bus traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dmdl_pkg::CfgIdxW-1:0] REG_UNUSED   = 2'd3;
  localparam logic [dmdl_pkg::ByteW-1:0]   CMD_STOP_ALL = 8'd30;
  localparam int                           RAISE        = 0;
  localparam int                           LOWER        = 1;
  localparam logic [3:0]                   MOTORS_RAISE = 4'b0101;
  localparam logic [3:0]                   MOTORS_LOWER = 4'b1010;
  localparam logic [1:0]                   VALVE_FWD    = 2'b01;
  localparam logic [1:0]                   VALVE_REV    = 2'b10;
  localparam int                           MAX_WAIT     = 17;
  localparam int                           STALL_LIMIT  = 1000;
  localparam int                           NUM_PHASES   = 8;

  typedef struct packed {
    logic [dmdl_pkg::ByteW-1:0] read_data;
    logic                       motor1_forward;
    logic                       motor1_reverse;
    logic                       motor2_forward;
    logic                       motor2_reverse;
    logic                       valve_forward;
    logic                       valve_reverse;
    logic                       raise_running;
    logic                       raise_cooling;
    logic                       lower_running;
    logic                       lower_cooling;
  } drive_word_t;

  typedef struct packed {
    logic [dmdl_pkg::OpW-1:0]   op;
    logic [dmdl_pkg::ByteW-1:0] data;
    logic                       fixed;
    drive_word_t                want;
  } stim_row_t;

  localparam stim_row_t DIR_ROWS [24] = '{
    {dmdl_pkg::OP_READ,    8'd0,   1'b1, 8'd0,   6'b000000, 4'b0000},
    {dmdl_pkg::OP_WRITE,   8'd255, 1'b1, 8'd0,   6'b000000, 4'b0000},
    {dmdl_pkg::OP_READ,    8'd0,   1'b1, 8'd255, 6'b000000, 4'b0000},
    {dmdl_pkg::OP_SET_POS, dmdl_pkg::POS_COMMAND, 1'b0, 18'd0},
    {dmdl_pkg::OP_WRITE,   dmdl_pkg::CMD_VALVE_FWD, 1'b1, 8'd0, 6'b000010, 4'b0000},
    {dmdl_pkg::OP_READ,    8'd0,   1'b1, dmdl_pkg::CMD_VALVE_FWD, 6'b000010, 4'b0000},
    {dmdl_pkg::OP_WRITE,   dmdl_pkg::CMD_VALVE_REV, 1'b1, 8'd0, 6'b000001, 4'b0000},
    {dmdl_pkg::OP_WRITE,   dmdl_pkg::CMD_VALVE_OFF, 1'b1, 8'd0, 6'b000000, 4'b0000},
    {dmdl_pkg::OP_WRITE,   dmdl_pkg::CMD_RAISE,     1'b1, 8'd0, 6'b101000, 4'b1000},
    {dmdl_pkg::OP_TICK,    8'd0,   1'b0, 18'd0},
    {dmdl_pkg::OP_WRITE,   dmdl_pkg::CMD_STOP_MOTORS, 1'b0, 18'd0},
    {dmdl_pkg::OP_WRITE,   dmdl_pkg::CMD_VALVE_FWD,   1'b0, 18'd0},
    {dmdl_pkg::OP_WRITE,   dmdl_pkg::CMD_LOWER,       1'b0, 18'd0},
    {dmdl_pkg::OP_WRITE,   CMD_STOP_ALL,    1'b1, 8'd0, 6'b000000, 4'b0000},
    {dmdl_pkg::OP_WRITE,   8'd255, 1'b1, 8'd0,   6'b000000, 4'b0000},
    {dmdl_pkg::OP_READ,    8'd0,   1'b1, 8'd255, 6'b000000, 4'b0000},
    {dmdl_pkg::OP_SET_POS, 8'd255, 1'b0, 18'd0},
    {dmdl_pkg::OP_WRITE,   8'hAA,  1'b0, 18'd0},
    {dmdl_pkg::OP_READ,    8'd0,   1'b1, 8'd0,   6'b000000, 4'b0000},
    {dmdl_pkg::OP_SET_POS, 8'd2,   1'b0, 18'd0},
    {dmdl_pkg::OP_READ,    8'd0,   1'b1, 8'd0,   6'b000000, 4'b0000},
    {dmdl_pkg::OP_SET_POS, dmdl_pkg::POS_COUNT, 1'b0, 18'd0},
    {dmdl_pkg::OP_READ,    8'd0,   1'b1, 8'd255, 6'b000000, 4'b0000},
    {dmdl_pkg::OP_TICK,    8'd255, 1'b0, 18'd0}
  };

  localparam int PH_RUN    [NUM_PHASES] = '{60, 1, 3, 5, 2, 65535, 257, 0};
  localparam int PH_FACTOR [NUM_PHASES] = '{9, 1, 2, 255, 1, 255, 255, 0};
  localparam int PH_TPS    [NUM_PHASES] = '{200, 1, 2, 1, 0, 65535, 1, 0};
  localparam int PH_ITEMS  [NUM_PHASES] = '{100, 200, 200, 150, 150, 100, 100, 200};

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_write;
  logic [dmdl_pkg::CfgIdxW-1:0]  cfg_index;
  logic [dmdl_pkg::CfgDataW-1:0] cfg_data;

  dmdl_in_if  in_ch ();
  dmdl_out_if out_ch ();

  door_motor_duty_limiter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state and its copy of the configuration.
  logic [dmdl_pkg::SecW-1:0]    run_limit;
  logic [dmdl_pkg::FactorW-1:0] cool_factor;
  logic [dmdl_pkg::TpsW-1:0]    tick_rate;
  logic [dmdl_pkg::TpsW-1:0]    tick_div;
  logic [dmdl_pkg::ByteW-1:0]   bus_pos;
  logic [dmdl_pkg::ByteW-1:0]   count_reg;
  logic [dmdl_pkg::ByteW-1:0]   cmd_reg;
  dmdl_pkg::duty_flags_t        duty_flag [2];
  dmdl_pkg::duty_timers_t       duty_time [2];
  logic [3:0]                   motor_lines;
  logic [1:0]                   valve_lines;

  drive_word_t pending_words [$];
  bit          failed = 1'b0;
  bit          quiet;
  int          idle_cycles = 0;

  function automatic logic [dmdl_pkg::SecW-1:0] sat_up(logic [dmdl_pkg::SecW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // One pass of the run/idle limit for one direction; returns 1 when the run restarts.
  function automatic bit duty_pass(int side, logic [3:0] lines);
    logic [31:0] need;
    need = 32'(cool_factor) * 32'(duty_time[side].run);
    if (duty_time[side].run > run_limit) begin
      motor_lines = '0;
      duty_flag[side].running = 1'b0;
      duty_flag[side].cooling = 1'b1;
      if (32'(duty_time[side].idle) >= need) begin
        duty_time[side].run = '0;
        return 1'b1;
      end
      return 1'b0;
    end
    motor_lines = lines;
    duty_flag[side].running = 1'b1;
    duty_flag[side].cooling = 1'b0;
    duty_time[side].idle = '0;
    return 1'b0;
  endfunction

  function automatic drive_word_t next_drive_word(logic [dmdl_pkg::OpW-1:0] op,
                                                  logic [dmdl_pkg::ByteW-1:0] data);
    drive_word_t w;
    logic [dmdl_pkg::ByteW-1:0] rd;
    rd = '0;
    case (op)
      dmdl_pkg::OP_TICK: begin
        tick_div = sat_up(tick_div);
        if (tick_div >= tick_rate) begin
          for (int s = 0; s < 2; s++) begin
            if (duty_flag[s].running) duty_time[s].run = sat_up(duty_time[s].run);
            if (duty_flag[s].cooling) duty_time[s].idle = sat_up(duty_time[s].idle);
          end
          tick_div = '0;
        end
      end
      dmdl_pkg::OP_SET_POS: bus_pos = data;
      dmdl_pkg::OP_WRITE: begin
        if (bus_pos == dmdl_pkg::POS_COUNT) count_reg = data;
        else if (bus_pos == dmdl_pkg::POS_COMMAND) cmd_reg = data;
      end
      default: begin
        if (bus_pos == dmdl_pkg::POS_COUNT) rd = count_reg;
        else if (bus_pos == dmdl_pkg::POS_COMMAND) rd = cmd_reg;
      end
    endcase
    case (cmd_reg)
      dmdl_pkg::CMD_RAISE: begin
        if (duty_pass(RAISE, MOTORS_RAISE)) void'(duty_pass(RAISE, MOTORS_RAISE));
      end
      dmdl_pkg::CMD_LOWER: begin
        if (duty_pass(LOWER, MOTORS_LOWER)) void'(duty_pass(LOWER, MOTORS_LOWER));
      end
      dmdl_pkg::CMD_VALVE_FWD: valve_lines = VALVE_FWD;
      dmdl_pkg::CMD_VALVE_REV: valve_lines = VALVE_REV;
      dmdl_pkg::CMD_VALVE_OFF: valve_lines = '0;
      default: begin
        motor_lines = '0;
        if (cmd_reg != dmdl_pkg::CMD_STOP_MOTORS) valve_lines = '0;
        for (int s = 0; s < 2; s++) begin
          duty_flag[s] = '0;
          duty_time[s] = '0;
        end
      end
    endcase
    w.read_data = rd;
    {w.motor2_reverse, w.motor2_forward, w.motor1_reverse, w.motor1_forward} = motor_lines;
    {w.valve_reverse, w.valve_forward} = valve_lines;
    w.raise_running = duty_flag[RAISE].running;
    w.raise_cooling = duty_flag[RAISE].cooling;
    w.lower_running = duty_flag[LOWER].running;
    w.lower_cooling = duty_flag[LOWER].cooling;
    return w;
  endfunction

  // Called just after a falling edge; returns just after the falling edge that follows the handshake.
  task automatic push_word(logic [dmdl_pkg::OpW-1:0] op, logic [dmdl_pkg::ByteW-1:0] data,
                           logic fixed, drive_word_t want);
    int gap;
    drive_word_t w;
    gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.operation = op;
    in_ch.data      = data;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    w = next_drive_word(op, data);
    pending_words.push_back(fixed ? want : w);
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [dmdl_pkg::CfgIdxW-1:0] idx,
                           logic [dmdl_pkg::CfgDataW-1:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      dmdl_pkg::REG_MAX_RUN: run_limit = value;
      dmdl_pkg::REG_FACTOR:  cool_factor = value[dmdl_pkg::FactorW-1:0];
      dmdl_pkg::REG_TPS:     tick_rate = value;
      default: ;
    endcase
  endtask

  task automatic pick_item(output logic [dmdl_pkg::OpW-1:0] op,
                           output logic [dmdl_pkg::ByteW-1:0] data);
    int r;
    int c;
    r    = $urandom_range(0, 99);
    c    = $urandom_range(0, 99);
    data = 8'($urandom_range(0, 255));
    if (r < 55) begin
      op = dmdl_pkg::OP_TICK;
    end else if (r < 65) begin
      op = dmdl_pkg::OP_SET_POS;
      if (c < 45) data = dmdl_pkg::POS_COUNT;
      else if (c < 90) data = dmdl_pkg::POS_COMMAND;
    end else if (r < 85) begin
      op = dmdl_pkg::OP_WRITE;
      if (bus_pos == dmdl_pkg::POS_COMMAND) begin
        if (c < 30) data = dmdl_pkg::CMD_RAISE;
        else if (c < 60) data = dmdl_pkg::CMD_LOWER;
        else if (c < 66) data = dmdl_pkg::CMD_VALVE_FWD;
        else if (c < 72) data = dmdl_pkg::CMD_VALVE_REV;
        else if (c < 78) data = dmdl_pkg::CMD_VALVE_OFF;
        else if (c < 84) data = dmdl_pkg::CMD_STOP_MOTORS;
        else if (c < 88) data = CMD_STOP_ALL;
      end
    end else begin
      op = dmdl_pkg::OP_READ;
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      failed = 1'b1;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result side: random stalls outside quiet phases, then compare each accepted word with the oldest expectation.
  initial begin
    int stall;
    drive_word_t want;
    out_ch.ready = 1'b0;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (rst || out_ch.valid !== 1'b1);
      if (pending_words.size() == 0) begin
        failed = 1'b1;
        $display("%0t: result word with no expectation waiting", $time);
      end else begin
        want = pending_words.pop_front();
        check_field("read_data", want.read_data, out_ch.read_data);
        check_field("motor1_forward", want.motor1_forward, out_ch.motor1_forward);
        check_field("motor1_reverse", want.motor1_reverse, out_ch.motor1_reverse);
        check_field("motor2_forward", want.motor2_forward, out_ch.motor2_forward);
        check_field("motor2_reverse", want.motor2_reverse, out_ch.motor2_reverse);
        check_field("valve_forward", want.valve_forward, out_ch.valve_forward);
        check_field("valve_reverse", want.valve_reverse, out_ch.valve_reverse);
        check_field("raise_running", want.raise_running, out_ch.raise_running);
        check_field("raise_cooling", want.raise_cooling, out_ch.raise_cooling);
        check_field("lower_running", want.lower_running, out_ch.lower_running);
        check_field("lower_cooling", want.lower_cooling, out_ch.lower_cooling);
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [dmdl_pkg::OpW-1:0]   op;
    logic [dmdl_pkg::ByteW-1:0] data;
    int                         rl;
    int                         fa;
    int                         tp;
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = dmdl_pkg::OP_TICK;
    in_ch.data      = '0;
    quiet           = 1'b0;
    run_limit       = dmdl_pkg::MAX_RUN_RESET;
    cool_factor     = dmdl_pkg::FACTOR_RESET;
    tick_rate       = dmdl_pkg::TPS_RESET;
    tick_div        = '0;
    bus_pos         = '0;
    count_reg       = '0;
    cmd_reg         = '0;
    motor_lines     = '0;
    valve_lines     = '0;
    for (int s = 0; s < 2; s++) begin
      duty_flag[s] = '0;
      duty_time[s] = '0;
    end
    repeat (2) @(negedge clk);
    rst = 1'b0;

    foreach (DIR_ROWS[i]) begin
      push_word(DIR_ROWS[i].op, DIR_ROWS[i].data, DIR_ROWS[i].fixed, DIR_ROWS[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      rl = PH_RUN[p];
      fa = PH_FACTOR[p];
      tp = PH_TPS[p];
      if (p == NUM_PHASES - 1) begin
        rl = $urandom_range(1, 6);
        fa = $urandom_range(1, 3);
        tp = $urandom_range(1, 3);
      end
      if (p == 1) write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
      write_reg(dmdl_pkg::REG_MAX_RUN, 16'(rl));
      write_reg(dmdl_pkg::REG_FACTOR, {8'($urandom_range(0, 255)), 8'(fa)});
      write_reg(dmdl_pkg::REG_TPS, 16'(tp));
      quiet = (p == 2);
      for (int n = 0; n < PH_ITEMS[p]; n++) begin
        pick_item(op, data);
        push_word(op, data, 1'b0, '0);
        if ($urandom_range(0, 99) == 0) settle();
      end
    end
    quiet = 1'b0;

    settle();
    repeat (10) @(posedge clk);
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
